// File: rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and character tables of the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

   // Number of digits in the scan loop
   localparam int DIGIT_COUNT = 4;

   // Request codes
   localparam logic [1:0] REQ_TEXT = 2'd0;
   localparam logic [1:0] REQ_INT  = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   // Fixed segment patterns (active low)
   localparam logic [7:0] PAT_BLANK   = 8'hFF;
   localparam logic [7:0] PAT_MINUS   = 8'hBF;
   localparam logic [7:0] PAT_DOT     = 8'd127;
   localparam logic [7:0] PAT_UNDER   = 8'd247;
   localparam logic [7:0] PAT_UNKNOWN = 8'd182;
   localparam logic [7:0] PAT_ERROR   = 8'd134;
   localparam logic [7:0] DP_MASK     = 8'h7F;
   localparam logic [7:0] SEL_BASE    = 8'hF0;

   // Integer display range
   localparam logic signed [31:0] INT_MIN_SHOWN = -32'sd999;
   localparam logic signed [31:0] INT_MAX_SHOWN = 32'sd9999;

   // Reciprocal of ten for values below ten thousand
   localparam logic [12:0] RECIP_TEN = 13'd6554;

   localparam logic [7:0] NUM_PAT [10] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
   };

   localparam logic [7:0] ALPHA_PAT [26] = '{
      8'd136, 8'd131, 8'd167, 8'd161, 8'd134, 8'd142, 8'd144, 8'd139, 8'd207,
      8'd241, 8'd182, 8'd199, 8'd182, 8'd171, 8'd163, 8'd140, 8'd152, 8'd175,
      8'd146, 8'd135, 8'd227, 8'd182, 8'd182, 8'd182, 8'd145, 8'd182
   };

   // Commands between front and back
   typedef enum logic {
      CMD_LOAD,
      CMD_SCAN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [3:0][7:0]  pats;
   } cmd_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [31:0]        text_chars;
      logic signed [31:0] int_value;
   } req_data_type;

   typedef struct packed {
      logic       serial_data;
      logic [1:0] digit_index;
      logic       latch_now;
   } rsp_data_type;

   // Map one character code to its segment pattern
   function automatic logic [7:0] char_to_pattern(input logic [7:0] c);
      logic [7:0] lc;
      logic [7:0] pat;
      lc = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         lc = c + 8'd32;
      end
      if (lc >= 8'h30 && lc <= 8'h39) begin
         pat = NUM_PAT[lc[3:0]];
      end else if (lc >= 8'hB0 && lc <= 8'hB9) begin
         pat = NUM_PAT[lc[3:0]] & DP_MASK;
      end else if (lc >= 8'h61 && lc <= 8'h7A) begin
         pat = ALPHA_PAT[lc[4:0] - 5'd1];
      end else if (lc == 8'h2D) begin
         pat = PAT_MINUS;
      end else if (lc == 8'h2E) begin
         pat = PAT_DOT;
      end else if (lc == 8'h5F) begin
         pat = PAT_UNDER;
      end else if (lc == 8'h20) begin
         pat = PAT_BLANK;
      end else begin
         pat = PAT_UNKNOWN;
      end
      return pat;
   endfunction

endpackage

// File: rtl/core/seven_segment_scan_driver_core.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_core
// Four-digit active-low seven-segment driver with serial scan output.
// ----------------------------------------------------------------------------
// Requests enter through req_push/req_full with a req_data struct: a text
// write (four characters), an integer write, or a refresh tick. Writes give
// no output; each tick gives sixteen rsp_data items, one serial bit each:
// the current digit's pattern, then its select byte, MSB first, with
// latch_now on the last bit. Results leave through rsp_empty/rsp_pop.
// A text write or tick goes straight to the command queue; an integer write
// keeps req_full high after it is taken while the front forms one decimal
// digit per step by the divide-by-ten (up to four), then queues the load.
// A scan command shifts out its sixteen bits, one output bit per cycle while
// rsp_pop is high; the back takes no new command until the last bit is sent.
// A two-entry command queue sits between front and back, so requests keep
// being taken while a digit is still shifting out.
// If the receiver stalls, the current bit holds on rsp_data, shifting stops,
// and the queue fills until req_full rises.
// Reset blanks all digits, sets the scan position to digit 0 and empties
// the queue and the output register.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_core import ssd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_data_type req_data,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_data_type rsp_data
);

   logic    cmd_push;
   logic    cmd_full;
   cmd_type cmd_in_data;
   logic    cmd_pop;
   logic    cmd_empty;
   cmd_type cmd_out_data;

   // Accept and classify requests
   ssd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (cmd_in_data)
   );

   // Decouple front and back
   ssd_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .full      (cmd_full),
      .push_data (cmd_in_data),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (cmd_out_data)
   );

   // Apply loads and shift out scans
   ssd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_out_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front
// Accepts requests, turns text and integers into segment patterns and issues
// load or scan commands to the command queue.
// ----------------------------------------------------------------------------
module ssd_front import ssd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_data_type req_data,
   output logic         cmd_push,
   input  logic         cmd_full,
   output cmd_type      cmd_data
);

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_FMT,
      FE_PUSH
   } fe_state_type;

   fe_state_type     fe_state_ff, fe_state_in;
   logic [13:0]      mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic [1:0]       pos_ff, pos_in;
   logic [3:0][7:0]  pat_ff, pat_in;

   logic             accept;
   logic             in_range;
   logic             is_neg;
   logic [31:0]      abs_val;
   logic [26:0]      prod;
   logic [13:0]      quot;
   logic [13:0]      rem_full;
   logic [3:0][7:0]  text_pats;

   assign req_full = (fe_state_ff != FE_IDLE) || cmd_full;
   assign accept   = req_push && !req_full;

   // Classify the integer and take its magnitude
   assign is_neg   = req_data.int_value < 0;
   assign in_range = (req_data.int_value >= INT_MIN_SHOWN) &&
                     (req_data.int_value <= INT_MAX_SHOWN);
   assign abs_val  = is_neg ? 32'(-req_data.int_value) : 32'(req_data.int_value);

   // One decimal digit per step: quotient by reciprocal, remainder by subtract
   assign prod     = 27'(mag_ff) * 27'(RECIP_TEN);
   assign quot     = 14'(prod >> 16);
   assign rem_full = mag_ff - 14'(quot * 14'd10);

   // Translate the four text characters
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         text_pats[i] = char_to_pattern(req_data.text_chars[8*i +: 8]);
      end
   end

   // Next state and command issue
   always_comb begin
      fe_state_in = fe_state_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      pos_in      = pos_ff;
      pat_in      = pat_ff;
      cmd_push    = 1'b0;
      cmd_data    = '{kind: CMD_LOAD, pats: pat_ff};
      unique case (fe_state_ff)
         FE_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_TEXT: begin
                     cmd_push = 1'b1;
                     cmd_data = '{kind: CMD_LOAD, pats: text_pats};
                  end
                  REQ_INT: begin
                     if (in_range) begin
                        mag_in      = abs_val[13:0];
                        neg_in      = is_neg;
                        pos_in      = 2'd3;
                        pat_in      = {4{PAT_BLANK}};
                        fe_state_in = FE_FMT;
                     end else begin
                        cmd_push = 1'b1;
                        cmd_data = '{kind: CMD_LOAD,
                                     pats: {PAT_ERROR, PAT_BLANK, PAT_BLANK, PAT_BLANK}};
                     end
                  end
                  REQ_TICK: begin
                     cmd_push = 1'b1;
                     cmd_data = '{kind: CMD_SCAN, pats: pat_ff};
                  end
                  default: begin
                     // drop unused request codes
                  end
               endcase
            end
         end
         FE_FMT: begin
            pat_in[pos_ff] = NUM_PAT[rem_full[3:0]];
            if (quot == 14'd0 || pos_ff == 2'd0) begin
               if (neg_ff && pos_ff != 2'd0) begin
                  pat_in[pos_ff - 2'd1] = PAT_MINUS;
               end
               fe_state_in = FE_PUSH;
            end else begin
               mag_in = quot;
               pos_in = pos_ff - 2'd1;
            end
         end
         FE_PUSH: begin
            if (!cmd_full) begin
               cmd_push    = 1'b1;
               fe_state_in = FE_IDLE;
            end
         end
         default: begin
            fe_state_in = FE_IDLE;
         end
      endcase
   end

   // Hold state and formatting registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fe_state_ff <= FE_IDLE;
      end else begin
         fe_state_ff <= fe_state_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      pos_ff <= pos_in;
      pat_ff <= pat_in;
   end

endmodule

// File: rtl/core/ssd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ssd_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module ssd_cmd_fifo import ssd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_data
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back
// Holds the digit patterns and scan position, applies load commands and
// shifts out one digit per scan command as sixteen serial bits.
// ----------------------------------------------------------------------------
module ssd_back import ssd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_empty,
   output logic         cmd_pop,
   input  cmd_type      cmd_data,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_data_type rsp_data
);

   typedef enum logic {
      BE_IDLE,
      BE_SHIFT
   } be_state_type;

   be_state_type    be_state_ff, be_state_in;
   logic [3:0][7:0] store_ff, store_in;
   logic [1:0]      scan_ff, scan_in;
   logic [15:0]     word_ff, word_in;
   logic [1:0]      idx_ff, idx_in;
   logic [3:0]      bit_ff, bit_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_data_type    rsp_ff, rsp_in;
   logic            slot_free;
   logic            scan_wrap;

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign cmd_pop   = (be_state_ff == BE_IDLE) && !cmd_empty;
   // Wrap at the last digit, or when the two-bit position runs out
   assign scan_wrap = (int'(scan_ff) == DIGIT_COUNT - 1) || (scan_ff == 2'd3);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      be_state_in  = be_state_ff;
      store_in     = store_ff;
      scan_in      = scan_ff;
      word_in      = word_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      unique case (be_state_ff)
         BE_IDLE: begin
            // Take the next command
            if (cmd_pop) begin
               if (cmd_data.kind == CMD_LOAD) begin
                  store_in = cmd_data.pats;
               end else begin
                  word_in     = {store_ff[scan_ff], SEL_BASE | (8'd1 << scan_ff)};
                  idx_in      = scan_ff;
                  bit_in      = 4'd0;
                  scan_in     = scan_wrap ? 2'd0 : scan_ff + 2'd1;
                  be_state_in = BE_SHIFT;
               end
            end
         end
         BE_SHIFT: begin
            // Shift one bit into the output register when it is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{serial_data: word_ff[15],
                                digit_index: idx_ff,
                                latch_now:   bit_ff == 4'd15};
               word_in      = {word_ff[14:0], 1'b0};
               bit_in       = bit_ff + 4'd1;
               if (bit_ff == 4'd15) begin
                  be_state_in = BE_IDLE;
               end
            end
         end
         default: begin
            be_state_in = BE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         be_state_ff  <= BE_IDLE;
         store_ff     <= {4{PAT_BLANK}};
         scan_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         be_state_ff  <= be_state_in;
         store_ff     <= store_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff <= word_in;
      idx_ff  <= idx_in;
      bit_ff  <= bit_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// File: tb/sv/scan_bit_checker.sv
// ----------------------------------------------------------------------------
// scan_bit_checker
// Watches both channels of the scan driver, predicts every serial bit and
// compares it with what the block sends out.
// ----------------------------------------------------------------------------
// Each accepted write updates a private copy of the digit patterns, each tick the
// scan position. A refresh tick queues sixteen expected bits: the pattern of
// the current digit, then its select byte, MSB first, with the latch flag on
// the last bit. Each accepted result is checked against the oldest entry.
// ----------------------------------------------------------------------------
module scan_bit_checker import ssd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         req_full,
   input  req_data_type req_data,
   input  logic         rsp_empty,
   input  logic         rsp_pop,
   input  rsp_data_type rsp_data,
   output int           error_count,
   output int           pending_count,
   output int           bits_checked
);

   // Segment patterns, active low, for '0'..'9' and 'a'..'z'
   localparam logic [7:0] DIGIT_SEGS [10] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
   };
   localparam logic [7:0] LETTER_SEGS [26] = '{
      8'h88, 8'h83, 8'hA7, 8'hA1, 8'h86, 8'h8E, 8'h90, 8'h8B, 8'hCF,
      8'hF1, 8'hB6, 8'hC7, 8'hB6, 8'hAB, 8'hA3, 8'h8C, 8'h98, 8'hAF,
      8'h92, 8'h87, 8'hE3, 8'hB6, 8'hB6, 8'hB6, 8'h91, 8'hB6
   };

   logic [7:0]   shown_pats [4];
   logic [1:0]   scan_pos;
   rsp_data_type expected_bits [$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      bits_checked  = 0;
   end

   // Map one character byte to the segment pattern it lights
   function automatic logic [7:0] segment_code_of(input logic [7:0] ch);
      logic [7:0] c;
      // fold upper case onto lower case
      c = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'd32 : ch;
      if (c >= 8'h30 && c <= 8'h39) return DIGIT_SEGS[c - 8'h30];
      // digit with the decimal point lit
      if (c >= 8'hB0 && c <= 8'hB9) return DIGIT_SEGS[c - 8'hB0] & 8'h7F;
      if (c >= 8'h61 && c <= 8'h7A) return LETTER_SEGS[c - 8'h61];
      if (c == 8'h2D) return 8'hBF;   // minus
      if (c == 8'h2E) return 8'h7F;   // dot
      if (c == 8'h5F) return 8'hF7;   // underscore
      if (c == 8'h20) return 8'hFF;   // space
      return 8'hB6;
   endfunction

   // Format an integer right-aligned in four places, or show the error mark
   task automatic load_integer(input logic signed [31:0] v);
      logic [7:0] txt [4];
      int         mag;
      int         pos;
      bit         neg;
      txt = '{8'h20, 8'h20, 8'h20, 8'h20};
      if (v < -999 || v > 9999) begin
         txt[3] = 8'h45;
      end else begin
         neg = v < 0;
         mag = neg ? -int'(v) : int'(v);
         pos = 3;
         do begin
            txt[pos] = 8'h30 + 8'(mag % 10);
            mag      = mag / 10;
            pos--;
         end while (mag != 0 && pos >= 0);
         if (neg && pos >= 0) begin
            txt[pos] = 8'h2D;
         end
      end
      for (int i = 0; i < 4; i++) begin
         shown_pats[i] = segment_code_of(txt[i]);
      end
   endtask

   // Queue the sixteen bits of one refresh and advance the scan position
   task automatic queue_scan_word();
      logic [15:0]  word;
      rsp_data_type bit_item;
      word = {shown_pats[scan_pos], SEL_BASE | (8'h01 << scan_pos)};
      for (int k = 0; k < 16; k++) begin
         bit_item.serial_data = word[15 - k];
         bit_item.digit_index = scan_pos;
         bit_item.latch_now   = (k == 15);
         expected_bits.push_back(bit_item);
      end
      scan_pos = 2'((int'(scan_pos) + 1) % DIGIT_COUNT);
   endtask

   // Check accepted results first, then fold in the accepted request
   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            shown_pats[i] = 8'hFF;
         end
         scan_pos = 2'd0;
         expected_bits.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_bits.size() == 0) begin
               error_count++;
               $display("%0t: unexpected scan bit: data=%0b digit=%0d latch=%0b",
                        $time, rsp_data.serial_data, rsp_data.digit_index,
                        rsp_data.latch_now);
            end else begin
               want = expected_bits.pop_front();
               bits_checked++;
               if (rsp_data.serial_data !== want.serial_data ||
                   rsp_data.digit_index !== want.digit_index ||
                   rsp_data.latch_now   !== want.latch_now) begin
                  error_count++;
                  $display({"%0t: scan bit mismatch: expected data=%0b digit=%0d ",
                            "latch=%0b, got data=%0b digit=%0d latch=%0b"},
                           $time, want.serial_data, want.digit_index, want.latch_now,
                           rsp_data.serial_data, rsp_data.digit_index,
                           rsp_data.latch_now);
               end
            end
         end
         if (req_push && !req_full) begin
            case (req_data.req_type)
               REQ_TEXT: begin
                  for (int i = 0; i < 4; i++) begin
                     shown_pats[i] = segment_code_of(req_data.text_chars[8*i +: 8]);
                  end
               end
               REQ_INT: begin
                  load_integer($signed(req_data.int_value));
               end
               REQ_TICK: begin
                  queue_scan_word();
               end
               default: begin
               end
            endcase
         end
      end
      pending_count = expected_bits.size();
   end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the seven-segment scan driver.
// ----------------------------------------------------------------------------
// A directed opening sweeps character classes, integer range edges and every
// request code, most writes followed by refresh ticks that bring digits out.
// A random mix of writes and ticks follows, with random gaps on the
// request side and random stalls on the result side, plus one long stretch
// at full rate. The checker beside the block reports the failure count.
// ----------------------------------------------------------------------------
module testbench;
   import ssd_pkg::*;

   // Request code the block must ignore
   localparam logic [1:0] REQ_UNUSED      = 2'd3;
   localparam int         RANDOM_REQUESTS = 350;
   localparam int         CYCLE_LIMIT     = 400000;
   localparam int         SETTLE_CYCLES   = 40;

   localparam int EDGE_VALUES [15] = '{
      -1000, -999, -998, -100, -10, -1, 0, 1, 9, 10, 999, 1000, 9998, 9999, 10000
   };

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         req_push = 1'b0;
   logic         rsp_pop  = 1'b0;
   req_data_type req_data = '0;
   logic         req_full;
   logic         rsp_empty;
   rsp_data_type rsp_data;

   int error_count;
   int pending_count;
   int bits_checked;
   int cycle_count = 0;
   int text_writes = 0;
   int int_writes  = 0;
   int tick_count  = 0;
   bit steady      = 1'b0;

   seven_segment_scan_driver_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   scan_bit_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .bits_checked  (bits_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the result side at random, except during the full-rate stretch
   always @(negedge clock) begin
      rsp_pop <= !reset && (steady || $urandom_range(99) >= 30);
   end

   // Hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Leftmost digit goes in the low byte
   function automatic logic [31:0] pack_chars(input logic [7:0] c0, c1, c2, c3);
      return {c3, c2, c1, c0};
   endfunction

   // Hold one request until it is taken, with random gaps in front of it
   task automatic send_request(input logic [1:0] kind, input logic [31:0] chars,
                               input logic signed [31:0] value);
      req_data_type item;
      item.req_type   = kind;
      item.text_chars = chars;
      item.int_value  = value;
      while (!steady && $urandom_range(99) < 30) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      if (kind == REQ_TEXT) text_writes++;
      if (kind == REQ_INT) int_writes++;
      if (kind == REQ_TICK) tick_count++;
      @(negedge clock);
   endtask

   initial begin
      int                 r;
      logic [31:0]        chars;
      logic signed [31:0] value;
      logic [7:0]         ch;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Letters of both cases and the digit extremes
      send_request(REQ_TEXT, pack_chars(8'h41, 8'h7A, 8'h30, 8'h39), $urandom);
      repeat (4) send_request(REQ_TICK, $urandom, $urandom);
      // Digits with decimal point, minus and dot
      send_request(REQ_TEXT, pack_chars(8'hB0, 8'hB9, 8'h2D, 8'h2E), $urandom);
      repeat (4) send_request(REQ_TICK, $urandom, $urandom);
      // Underscore, space, and two bytes with no pattern
      send_request(REQ_TEXT, pack_chars(8'h5F, 8'h20, 8'h00, 8'hFF), $urandom);
      repeat (4) send_request(REQ_TICK, $urandom, $urandom);
      // Integer range edges, out-of-range mark and the ignored request code
      send_request(REQ_INT, $urandom, 32'sd9999);
      repeat (4) send_request(REQ_TICK, $urandom, $urandom);
      send_request(REQ_INT, $urandom, -32'sd999);
      repeat (2) send_request(REQ_TICK, $urandom, $urandom);
      send_request(REQ_INT, $urandom, 32'sd10000);
      send_request(REQ_UNUSED, $urandom, $urandom);
      repeat (2) send_request(REQ_TICK, $urandom, $urandom);
      send_request(REQ_INT, $urandom, 32'h8000_0000);

      // Random mix, half of it ticks so that writes show up on the output
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         steady = (n >= 120 && n < 200);
         r = $urandom_range(99);
         if (r < 50) begin
            send_request(REQ_TICK, $urandom, $urandom);
         end else if (r < 72) begin
            for (int i = 0; i < 4; i++) begin
               case ($urandom_range(6))
                  0: ch = 8'h41 + 8'($urandom_range(25));
                  1: ch = 8'h61 + 8'($urandom_range(25));
                  2: ch = 8'h30 + 8'($urandom_range(9));
                  3: ch = 8'hB0 + 8'($urandom_range(9));
                  4: ch = 8'(pack_chars(8'h2D, 8'h2E, 8'h5F, 8'h20) >>
                             (8 * $urandom_range(3)));
                  default: ch = 8'($urandom_range(255));
               endcase
               chars[8*i +: 8] = ch;
            end
            send_request(REQ_TEXT, chars, $urandom);
         end else if (r < 95) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: value = $urandom_range(11100) - 1100;
               6, 7: value = EDGE_VALUES[$urandom_range(14)];
               default: value = $urandom;
            endcase
            send_request(REQ_INT, $urandom, value);
         end else begin
            send_request(REQ_UNUSED, $urandom, $urandom);
         end
      end
      steady = 1'b0;
      req_push <= 1'b0;

      // Drain, then allow the block time for anything unexpected
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d text writes, %0d integer writes and %0d refresh ticks;",
               text_writes, int_writes, tick_count);
      $display("compared %0d serial bits against the prediction.", bits_checked);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
